// ===== design/smx_pkg.sv =====
// Shared types and constants of the stack machine executor.
package smx_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    typedef enum logic [3:0] {
        FN_PUSH = 4'd0,
        FN_POP  = 4'd1,
        FN_ADD  = 4'd2,
        FN_SUB  = 4'd3,
        FN_MUL  = 4'd4,
        FN_DIV  = 4'd5,
        FN_HALT = 4'd6,
        FN_OUT  = 4'd7
    } t_func;

    localparam logic [1:0] KIND_VALUE  = 2'd0;
    localparam logic [1:0] KIND_HALTED = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_UNKNOWN   = 2'd0;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
    localparam logic [1:0] ERR_DIVZERO   = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD_ABOVE = 2'd1,
        CELL_LOAD_BELOW = 2'd2
    } t_cell_op;

endpackage

// ===== design/smx_cell.sv =====
// One stack entry: holds its word or takes the word of a neighbor.
module smx_cell (
    input  logic                       i_clk,
    input  smx_pkg::t_cell_op          i_op,
    input  logic [smx_pkg::DATA_W-1:0] i_above,
    input  logic [smx_pkg::DATA_W-1:0] i_below,
    output logic [smx_pkg::DATA_W-1:0] o_value
);

    logic [smx_pkg::DATA_W-1:0] r_value;
    logic [smx_pkg::DATA_W-1:0] n_value;

    always_comb begin
        unique case (i_op)
            smx_pkg::CELL_LOAD_ABOVE: n_value = i_above;
            smx_pkg::CELL_LOAD_BELOW: n_value = i_below;
            default:                  n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== design/smx_div.sv =====
// Radix-2 restoring divider, signed, truncating toward zero.
module smx_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [smx_pkg::DATA_W-1:0] i_dividend,
    input  logic [smx_pkg::DATA_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [smx_pkg::DATA_W-1:0] o_quotient
);

    localparam int W     = smx_pkg::DATA_W;
    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_q;
    logic [W-1:0]     r_d;

    logic [W:0]       w_trial;
    logic             w_ge;
    logic [W:0]       w_diff;

    assign w_trial = {r_rem, r_q[W-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[W-1] ^ i_divisor[W-1];
            r_rem <= '0;
            r_q   <= i_dividend[W-1] ? (W'(0) - i_dividend) : i_dividend;
            r_d   <= i_divisor[W-1] ? (W'(0) - i_divisor) : i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits in W bits
            r_rem <= w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
            r_q   <= {r_q[W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (W'(0) - r_q) : r_q;

endmodule

// ===== design/stack_machine_executor_unit.sv =====
// Top level of the stack machine executor: control, output register, cell chain.
// Executes one decoded instruction per request on a 64-entry stack held as a
// chain of cells, top of stack in cell 0; push shifts the chain down, out and
// write back shift it up, pop leaves it. A request is taken only while the
// sequencer is idle. Push, pop, out, halt and error cases end in execute; add,
// sub and mul go on to the result register and write back, div to the 32-step
// bit-serial divider and then write back. An error or output result waits in
// the output register; the sequencer holds an item that must report until that
// register frees up. After halt every request is taken and dropped until reset.
module stack_machine_executor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_func,
    input  logic        i_has_immediate,
    input  logic signed [31:0] i_immediate,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic signed [31:0] o_value,
    output logic [1:0]  o_error_code
);

    localparam int N  = smx_pkg::STACK_DEPTH;
    localparam int DW = smx_pkg::DEPTH_W;
    localparam int W  = smx_pkg::DATA_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_DIV  = 5'b00100,
        S_WAIT = 5'b01000,
        S_WB   = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [DW-1:0]     r_depth, n_depth;
    logic              r_halted, n_halted;
    logic [3:0]        r_func;
    logic              r_has_imm;
    logic [W-1:0]      r_imm;
    logic [W-1:0]      r_res, n_res;

    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_kind, n_kind;
    logic [W-1:0]      r_value, n_value;
    logic [1:0]        r_err, n_err;

    logic              w_emit;
    logic [1:0]        w_kind;
    logic [1:0]        w_err;
    logic              w_can_emit;
    logic              w_go;
    logic              w_div_start;
    logic              w_div_done;
    logic [W-1:0]      w_quot;
    logic [W-1:0]      w_top_in;
    smx_pkg::t_cell_op w_op_top;
    smx_pkg::t_cell_op w_op_rest;
    logic [W-1:0]      w_cell [N];
    logic              w_accept;

    assign w_accept   = i_valid && o_ready;
    assign w_can_emit = !r_out_valid || i_ready;

    // decide whether the held item reports, and with what
    always_comb begin
        w_emit = 1'b0;
        w_kind = smx_pkg::KIND_ERROR;
        w_err  = smx_pkg::ERR_UNKNOWN;
        case (r_func)
            smx_pkg::FN_PUSH: begin
                if (r_depth >= DW'(N)) begin
                    w_emit = 1'b1;
                    w_err  = smx_pkg::ERR_OVERFLOW;
                end
            end
            smx_pkg::FN_POP: begin
                w_emit = 1'b0;
            end
            smx_pkg::FN_ADD, smx_pkg::FN_SUB, smx_pkg::FN_MUL, smx_pkg::FN_DIV: begin
                if (r_depth < DW'(2)) begin
                    w_emit = 1'b1;
                    w_err  = smx_pkg::ERR_UNDERFLOW;
                end else if (r_func == smx_pkg::FN_DIV && w_cell[0] == '0) begin
                    w_emit = 1'b1;
                    w_err  = smx_pkg::ERR_DIVZERO;
                end
            end
            smx_pkg::FN_HALT: begin
                w_emit = 1'b1;
                w_kind = smx_pkg::KIND_HALTED;
            end
            smx_pkg::FN_OUT: begin
                w_emit = 1'b1;
                if (r_depth == '0) begin
                    w_err = smx_pkg::ERR_UNDERFLOW;
                end else begin
                    w_kind = smx_pkg::KIND_VALUE;
                end
            end
            default: begin
                w_emit = 1'b1;
                w_err  = smx_pkg::ERR_UNKNOWN;
            end
        endcase
    end

    assign w_go = (r_state == S_EXEC) && (!w_emit || w_can_emit);

    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_halted    = r_halted;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_ready;
        n_kind      = r_kind;
        n_value     = r_value;
        n_err       = r_err;
        w_div_start = 1'b0;
        w_op_top    = smx_pkg::CELL_HOLD;
        w_op_rest   = smx_pkg::CELL_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && !r_halted) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_go) begin
                    n_state = S_IDLE;
                    if (w_emit) begin
                        n_out_valid = 1'b1;
                        n_kind      = w_kind;
                        n_err       = (w_kind == smx_pkg::KIND_ERROR) ? w_err
                                                                      : smx_pkg::ERR_UNKNOWN;
                        n_value     = (w_kind == smx_pkg::KIND_VALUE) ? w_cell[0] : '0;
                    end
                    if (w_kind == smx_pkg::KIND_HALTED && w_emit) begin
                        n_halted = 1'b1;
                    end else if (w_emit && w_kind == smx_pkg::KIND_VALUE) begin
                        w_op_top  = smx_pkg::CELL_LOAD_BELOW;
                        w_op_rest = smx_pkg::CELL_LOAD_BELOW;
                        n_depth   = r_depth - DW'(1);
                    end else if (!w_emit) begin
                        case (r_func)
                            smx_pkg::FN_PUSH: begin
                                w_op_top  = smx_pkg::CELL_LOAD_ABOVE;
                                w_op_rest = smx_pkg::CELL_LOAD_ABOVE;
                                n_depth   = r_depth + DW'(1);
                            end
                            smx_pkg::FN_ADD: begin
                                n_res   = w_cell[1] + w_cell[0];
                                n_state = S_WB;
                            end
                            smx_pkg::FN_SUB: begin
                                n_res   = w_cell[1] - w_cell[0];
                                n_state = S_WB;
                            end
                            smx_pkg::FN_MUL: begin
                                n_res   = W'(w_cell[1] * w_cell[0]);
                                n_state = S_WB;
                            end
                            smx_pkg::FN_DIV: begin
                                w_div_start = 1'b1;
                                n_state     = S_DIV;
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_DIV: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_div_done) begin
                    n_res   = w_quot;
                    n_state = S_WB;
                end
            end
            S_WB: begin
                // replace the two operands by the result
                w_op_top  = smx_pkg::CELL_LOAD_ABOVE;
                w_op_rest = smx_pkg::CELL_LOAD_BELOW;
                n_depth   = r_depth - DW'(1);
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func    <= i_func;
            r_has_imm <= i_has_immediate;
            r_imm     <= i_immediate;
        end
        r_res   <= n_res;
        r_kind  <= n_kind;
        r_value <= n_value;
        r_err   <= n_err;
    end

    assign w_top_in = (r_state == S_WB) ? r_res : (r_has_imm ? r_imm : '0);

    smx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_cell[1]),
        .i_divisor  (w_cell[0]),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [W-1:0] w_above;
        logic [W-1:0] w_below;
        if (g == 0) begin : g_first
            assign w_above = w_top_in;
        end else begin : g_mid
            assign w_above = w_cell[g-1];
        end
        if (g == N - 1) begin : g_last
            assign w_below = w_cell[g];
        end else begin : g_inner
            assign w_below = w_cell[g+1];
        end
        smx_cell u_cell (
            .i_clk   (i_clk),
            .i_op    ((g == 0) ? w_op_top : w_op_rest),
            .i_above (w_above),
            .i_below (w_below),
            .o_value (w_cell[g])
        );
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_kind       = r_kind;
    assign o_value      = r_value;
    assign o_error_code = r_err;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(N))
        else $error("stack depth beyond capacity");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted && $stable(r_depth))
        else $error("state changed after halt");

    a_halted_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == smx_pkg::KIND_HALTED) |-> r_halted)
        else $error("halted result without halt flag");

    a_code_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != smx_pkg::KIND_ERROR) |-> (o_error_code == smx_pkg::ERR_UNKNOWN))
        else $error("error code set on non-error result");

endmodule
